/* sv/szod_pkg.sv */
`timescale 1ns / 1ps
package szod_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int XY_W         = 35;
    localparam int Z_W          = ANGLE_BITS + 1;
    localparam int ADDR_W       = 4;

    localparam logic [15:0] GAIN_INV_Q16   = 16'd39797;
    localparam logic [15:0] QUARTER_TURN16 = 16'd16384;
    localparam logic [14:0] STEP_RESET     = 15'd16;

    localparam logic [31:0] ATAN_TURN32 [25] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41
    };

    typedef enum logic [1:0] {
        REG_START_ANGLE = 2'd0,
        REG_ANGLE_STEP  = 2'd1,
        REG_ZONE_WIDTH  = 2'd2,
        REG_ZONE_DEPTH  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic                   live;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cell;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } t_flag;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic [32:0] sum;
        sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ANGLE_BITS));
        return Z_W'(sum >> (32 - ANGLE_BITS));
    endfunction

endpackage

/* sv/szod_prep.sv */
`timescale 1ns / 1ps
module szod_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [15:0]     i_range_mm,
    input  logic            i_last_sample,
    input  logic [15:0]     i_start_angle,
    input  logic [14:0]     i_angle_step,
    output szod_pkg::t_cell o_q
);
    import szod_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] MSB = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    logic [15:0]           r_beam_angle;
    logic                  r_scan_begin;
    t_cell                 r_q;
    logic [15:0]           w_angle;
    logic [15:0]           w_theta;
    logic [23:0]           w_wide;
    logic [ANGLE_BITS-1:0] w_z;
    logic                  w_fold;
    logic [31:0]           w_prod;
    logic signed [XY_W-1:0] w_x;
    t_cell                 n_q;

    always_comb begin
        w_angle = r_scan_begin ? i_start_angle : r_beam_angle;
        w_theta = w_angle + QUARTER_TURN16;
        w_wide  = {w_theta, 8'd0};
        w_z     = ANGLE_BITS'(w_wide >> (24 - ANGLE_BITS));
        w_fold  = (w_z[ANGLE_BITS-1] ^ w_z[ANGLE_BITS-2]) && (w_z != QTR);
        w_prod  = 32'(i_range_mm) * 32'(GAIN_INV_Q16);
        w_x     = $signed({{(XY_W-32){1'b0}}, w_prod});
        n_q.valid = i_valid;
        n_q.last  = i_last_sample;
        n_q.live  = (i_range_mm != 16'd0);
        n_q.x     = w_fold ? -w_x : w_x;
        n_q.y     = '0;
        n_q.z     = Z_W'($signed(w_fold ? (w_z ^ MSB) : w_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_angle <= 16'd0;
            r_scan_begin <= 1'b1;
            r_q.valid    <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
            if (i_valid) begin
                r_beam_angle <= w_angle + {1'b0, i_angle_step};
                r_scan_begin <= i_last_sample;
            end
        end
    end

    assign o_q = r_q;

endmodule

/* sv/szod_cell.sv */
`timescale 1ns / 1ps
module szod_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [szod_pkg::STEP_W-1:0] i_step,
    input  szod_pkg::t_cell         i_d,
    output szod_pkg::t_cell         o_q
);
    import szod_pkg::*;

    t_cell                  r_q;
    t_cell                  n_q;
    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic signed [Z_W-1:0]  w_a;

    always_comb begin
        w_dx = i_d.y >>> i_step;
        w_dy = i_d.x >>> i_step;
        w_a  = atan_step(i_step);
        n_q  = i_d;
        if (!i_d.z[Z_W-1]) begin
            n_q.x = i_d.x - w_dx;
            n_q.y = i_d.y + w_dy;
            n_q.z = i_d.z - w_a;
        end else begin
            n_q.x = i_d.x + w_dx;
            n_q.y = i_d.y - w_dy;
            n_q.z = i_d.z + w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* sv/szod_zone.sv */
`timescale 1ns / 1ps
module szod_zone (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  szod_pkg::t_cell i_d,
    input  logic [15:0]     i_zone_width,
    input  logic [15:0]     i_zone_depth,
    output szod_pkg::t_flag o_q
);
    import szod_pkg::*;

    t_flag           r_q;
    t_flag           n_q;
    logic [XY_W-1:0] w_ax;
    logic [XY_W:0]   w_ax2;
    logic [XY_W:0]   w_wlim;
    logic [XY_W-1:0] w_dlim;
    logic            w_in_x;
    logic            w_in_y;

    always_comb begin
        w_ax   = i_d.x[XY_W-1] ? XY_W'(-i_d.x) : XY_W'(i_d.x);
        w_ax2  = {w_ax, 1'b0};
        w_wlim = (XY_W+1)'({i_zone_width, 16'd0});
        w_dlim = XY_W'({i_zone_depth, 16'd0});
        w_in_x = (w_ax2 <= w_wlim);
        w_in_y = !i_d.y[XY_W-1] && (XY_W'(i_d.y) <= w_dlim);
        n_q.valid = i_d.valid;
        n_q.last  = i_d.last;
        n_q.hit   = i_d.live && w_in_x && w_in_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* sv/scan_zone_obstacle_detect_core.sv */
`timescale 1ns / 1ps
// Registers in order: prep, one per CORDIC step, zone check, result beat.
// Throughput: one sample per cycle; the prep stage, one cell per CORDIC step and the
// zone check form a pipeline that holds as a whole while a result beat waits.
// Reset (synchronous, active low): pipeline emptied, next sample starts a scan,
// start_angle/zone_width/zone_depth cleared, angle_step set to 16.
module scan_zone_obstacle_detect_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_range_mm,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_obstacle,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [szod_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import szod_pkg::*;

    logic [15:0] r_start_angle;
    logic [14:0] r_angle_step;
    logic [15:0] r_zone_width;
    logic [15:0] r_zone_depth;
    logic        r_hit_seen;
    logic        r_out_valid;
    logic        r_obstacle;
    logic        w_adv;
    logic        w_hit;
    t_reg_idx    w_idx;
    t_cell       w_chain [CORDIC_STEPS+1];
    t_flag       w_flag;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_idx      = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready     = 1'b1;

    always_comb begin
        case (w_idx)
            REG_START_ANGLE: prdata = {{16{r_start_angle[15]}}, r_start_angle};
            REG_ANGLE_STEP:  prdata = {17'd0, r_angle_step};
            REG_ZONE_WIDTH:  prdata = {16'd0, r_zone_width};
            REG_ZONE_DEPTH:  prdata = {16'd0, r_zone_depth};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= 16'd0;
            r_angle_step  <= STEP_RESET;
            r_zone_width  <= 16'd0;
            r_zone_depth  <= 16'd0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_START_ANGLE: r_start_angle <= pwdata[15:0];
                REG_ANGLE_STEP:  r_angle_step  <= pwdata[14:0];
                REG_ZONE_WIDTH:  r_zone_width  <= pwdata[15:0];
                REG_ZONE_DEPTH:  r_zone_depth  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    szod_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (i_in_valid),
        .i_range_mm    (i_range_mm),
        .i_last_sample (i_last_sample),
        .i_start_angle (r_start_angle),
        .i_angle_step  (r_angle_step),
        .o_q           (w_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        szod_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_step  (STEP_W'(g)),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    szod_zone u_zone (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_d          (w_chain[CORDIC_STEPS]),
        .i_zone_width (r_zone_width),
        .i_zone_depth (r_zone_depth),
        .o_q          (w_flag)
    );

    assign w_hit = r_hit_seen || w_flag.hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_flag.valid && w_flag.last;
            if (w_flag.valid) begin
                r_hit_seen <= w_hit && !w_flag.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_flag.valid && w_flag.last) begin
            r_obstacle <= w_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_obstacle  = r_obstacle;

endmodule

/* dv/szod_checker.sv */
`timescale 1ns / 1ps
module szod_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic [15:0]                 i_range_mm,
    input  logic                        i_last_sample,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        o_obstacle,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [szod_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          pending
);
    import szod_pkg::*;

    logic [15:0] start_angle;
    logic [14:0] angle_step;
    logic [15:0] zone_width;
    logic [15:0] zone_depth;
    logic [15:0] next_angle;
    bit          hit_held;
    bit          scan_fresh;
    bit          obstacle_due[$];
    logic [15:0] beam;
    bit          scan_hit;
    bit          due;

    // Rotate the range onto the beam angle and test the point against the rectangle.
    function automatic bit beam_hits_zone(input logic [15:0] reach, input logic [15:0] theta);
        longint full, half, quarter, z, x, y, ax, dx, dy, turn_step;
        full    = longint'(1) << ANGLE_BITS;
        half    = full >> 1;
        quarter = full >> 2;
        z = longint'((64'(theta) << 8) >> (24 - ANGLE_BITS));
        x = longint'(reach) * longint'(GAIN_INV_Q16);
        y = 0;
        if (z >= half)
            z -= full;
        if (z > quarter || z < -quarter) begin
            x = -x;
            z = (z > 0) ? z - half : z + half;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 25; i++) begin
            turn_step = longint'((64'(ATAN_TURN32[i]) + (64'd1 << (31 - ANGLE_BITS)))
                                 >> (32 - ANGLE_BITS));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= turn_step;
            end else begin
                x += dx;
                y -= dy;
                z += turn_step;
            end
        end
        ax = (x < 0) ? -x : x;
        if (2 * ax > (longint'(zone_width) << 16))
            return 1'b0;
        if (y < 0 || y > (longint'(zone_depth) << 16))
            return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_angle = '0;
            angle_step  = STEP_RESET;
            zone_width  = '0;
            zone_depth  = '0;
            next_angle  = '0;
            hit_held    = 1'b0;
            scan_fresh  = 1'b1;
            obstacle_due.delete();
            mismatches <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_START_ANGLE: start_angle = pwdata[15:0];
                    REG_ANGLE_STEP:  angle_step  = pwdata[14:0];
                    REG_ZONE_WIDTH:  zone_width  = pwdata[15:0];
                    REG_ZONE_DEPTH:  zone_depth  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                beam     = scan_fresh ? start_angle : next_angle;
                scan_hit = scan_fresh ? 1'b0 : hit_held;
                if (i_range_mm != 0 && beam_hits_zone(i_range_mm, beam + QUARTER_TURN16))
                    scan_hit = 1'b1;
                next_angle = beam + {1'b0, angle_step};
                if (i_last_sample) begin
                    obstacle_due.push_back(scan_hit);
                    hit_held   = 1'b0;
                    scan_fresh = 1'b1;
                end else begin
                    hit_held   = scan_hit;
                    scan_fresh = 1'b0;
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (obstacle_due.size() == 0) begin
                    $error("obstacle: expected no beat, got %0b", o_obstacle);
                    mismatches <= mismatches + 1;
                end else begin
                    due = obstacle_due.pop_front();
                    if (o_obstacle !== due) begin
                        $error("obstacle: expected %0b, got %0b", due, o_obstacle);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        pending <= obstacle_due.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import szod_pkg::*;

    localparam int SETTLE_CYCLES = CORDIC_STEPS + 3 + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [15:0]        i_range_mm    = '0;
    logic               i_last_sample = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic               o_obstacle;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    int          mismatches;
    int          pending;
    int          cycles      = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;
    bit          hold_arm    = 1'b0;
    bit          hold_taken  = 1'b0;
    logic [15:0] cur_width   = '0;
    logic [15:0] cur_depth   = '0;

    scan_zone_obstacle_detect_core dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_range_mm, .i_last_sample,
        .o_out_valid, .i_out_ready, .o_obstacle,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    szod_checker flag_check (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_range_mm, .i_last_sample,
        .o_out_valid, .i_out_ready, .o_obstacle,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .mismatches, .pending
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[scan_zone_obstacle_detect_core] ERROR");
            $finish;
        end
    end

    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Result side: random stalls, plus one long hold to back the pipeline up.
    always @(posedge i_clk) begin
        int span;
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            span = idle_span();
            if (span > 0) begin
                stall_left = span - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pick_reach();
        int roll, lim;
        roll = $urandom_range(0, 99);
        lim  = (cur_width > cur_depth) ? int'(cur_width) : int'(cur_depth);
        lim  = lim + lim / 4 + 16;
        if (lim > 65535)
            lim = 65535;
        if (roll < 10)
            return 16'd0;
        if (roll < 60)
            return 16'($urandom_range(1, lim));
        if (roll < 65)
            return (roll < 63) ? 16'hFFFF : 16'd1;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] sa, input logic [14:0] st,
                                 input logic [15:0] w, input logic [15:0] d);
        reg_write(REG_START_ANGLE, {16'd0, sa});
        reg_write(REG_ANGLE_STEP, {17'd0, st});
        reg_write(REG_ZONE_WIDTH, {16'd0, w});
        reg_write(REG_ZONE_DEPTH, {16'd0, d});
        cur_width = w;
        cur_depth = d;
    endtask

    task automatic put_sample(input logic [15:0] reach, input bit last);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_range_mm    <= reach;
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drain every result, then let the pipeline empty before touching registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_scans(input int quota);
        int sent, len, roll;
        sent = 0;
        while (sent < quota) begin
            roll = $urandom_range(0, 99);
            len  = (roll < 20) ? 1 : (roll < 70) ? $urandom_range(2, 8) : $urandom_range(9, 60);
            for (int k = 0; k < len; k++)
                put_sample(pick_reach(), k == len - 1);
            sent += len;
        end
        settle();
    endtask

    initial begin
        logic [15:0] sa;
        logic [14:0] st;
        logic [15:0] w;
        logic [15:0] d;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // forward zone: empty returns, inside, on the far edge, beyond, sticky hit
        apply_setting(16'd0, 15'd16, 16'd2000, 16'd3000);
        put_sample(16'd0, 1'b1);
        put_sample(16'd1000, 1'b1);
        put_sample(16'd3000, 1'b1);
        put_sample(16'd3001, 1'b1);
        put_sample(16'hFFFF, 1'b1);
        put_sample(16'd0, 1'b0);
        put_sample(16'hFFFF, 1'b0);
        put_sample(16'd1500, 1'b0);
        put_sample(16'd0, 1'b1);
        put_sample(16'hFFFF, 1'b0);
        put_sample(16'd0, 1'b1);
        settle();

        // largest step: beam angles wrap round the full turn
        apply_setting(16'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF);
        put_sample(16'hFFFF, 1'b0);
        put_sample(16'd1, 1'b0);
        put_sample(16'd40000, 1'b0);
        put_sample(16'hFFFF, 1'b0);
        put_sample(16'd20000, 1'b1);
        settle();

        // degenerate zone, beam pointing backwards
        apply_setting(16'h8000, 15'd0, 16'd0, 16'd0);
        put_sample(16'd1, 1'b1);
        put_sample(16'hFFFF, 1'b1);
        put_sample(16'd0, 1'b1);
        settle();

        // sweep from lateral past forward across a shallow zone
        apply_setting(16'hC000, 15'd8192, 16'hFFFF, 16'd100);
        put_sample(16'd5000, 1'b0);
        put_sample(16'd5000, 1'b0);
        put_sample(16'd5000, 1'b0);
        put_sample(16'd5000, 1'b1);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    st = 15'($urandom_range(4, 200));
                    sa = 16'(-(int'(st) * 6));
                    w  = 16'($urandom_range(500, 6000));
                    d  = 16'($urandom_range(500, 6000));
                end
                1: begin
                    sa = 16'h7FFF; st = 15'h7FFF; w = 16'hFFFF; d = 16'hFFFF;
                end
                2: begin
                    sa = 16'h8000; st = 15'd0; w = 16'd0; d = 16'd0;
                end
                3: begin
                    sa = 16'd0; st = 15'd0; w = 16'd0; d = 16'hFFFF;
                end
                default: begin
                    sa = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 8000) - 4000);
                    st = ($urandom_range(0, 1) != 0) ? 15'($urandom_range(0, 300))
                                                    : 15'($urandom_range(0, 32767));
                    w  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 5000));
                    d  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 5000));
                end
            endcase
            apply_setting(sa, st, w, d);
            calm = (phase == 4 || phase == 6);
            if (phase == 0)
                hold_arm <= 1'b1;
            run_scans(175);
        end

        if (mismatches == 0 && pending == 0)
            $display("[scan_zone_obstacle_detect_core] OK");
        else
            $display("[scan_zone_obstacle_detect_core] ERROR");
        $finish;
    end

endmodule
